// ===== hdl/cfpa_pkg.sv =====
// Shared types and constants for the car-following path advance block.
// No dependencies; imported by car_following_path_advance.
package cfpa_pkg;

    localparam int MAX_EDGES = 32;
    localparam int EDGE_AW   = 5;

    localparam logic [30:0] Q_MAX31 = 31'h7FFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CFG_MAX_ACCEL   = 3'd0,
        CFG_BRAKE_DECEL = 3'd1,
        CFG_MAX_VEL     = 3'd2,
        CFG_SAFETY_DIST = 3'd3,
        CFG_TICKS       = 3'd4,
        CFG_PATH_EDGES  = 3'd5
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        KIND_PASSED  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

endpackage

// ===== hdl/car_following_path_advance.sv =====
// Car-following path advance: top level with edge-length memory and sequencer.
// Depends on cfpa_pkg.
// A load request writes the edge memory; the sequencer stays idle. A tick request
// that is not a plain follow (stop, no leader, braking leader) goes straight to the
// update, speed divider and edge walk; a following tick first runs 8 multiply steps,
// a 64-step divider, 4 partial products, a 64-step square root and 5 single steps.
// Output stalls hold the sequencer. One request at a time; results leave via an output
// register. Synchronous active-low reset clears control, config, vehicle and valid state.
module car_following_path_advance
    import cfpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [4:0]  s_edge_slot,
    input  logic [30:0] s_edge_length,
    input  logic        s_stop_command,
    input  logic        s_has_leader,
    input  logic        s_leader_braking,
    input  logic [30:0] s_leader_velocity,
    input  logic [30:0] s_leader_brake,
    input  logic signed [31:0] s_gap,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [4:0]  m_passed_edge,
    output logic [30:0] m_new_velocity,
    output logic signed [31:0] m_applied_accel,
    output logic [4:0]  m_edge_now,
    output logic [30:0] m_edge_offset,
    output logic        m_runway_ready,
    output logic [31:0] m_waited_ticks,
    output logic [31:0] m_stopped_ticks,
    output logic        m_last
);

    // Sequencer: the follow path runs MUL -> DIV -> HCALC -> KH -> PQ -> DIFF
    // -> SQRT -> ACC1 -> ACC2, then all tick paths run UPD -> SDIV -> RD/WALK -> SUM.
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_MUL   = 16'h0002,
        S_DIV   = 16'h0004,
        S_HCALC = 16'h0008,
        S_KH    = 16'h0010,
        S_PQ    = 16'h0020,
        S_DIFF  = 16'h0040,
        S_SQRT  = 16'h0080,
        S_ACC1  = 16'h0100,
        S_ACC2  = 16'h0200,
        S_UPD   = 16'h0400,
        S_SDIV  = 16'h0800,
        S_RD    = 16'h1000,
        S_WALK  = 16'h2000,
        S_SUM   = 16'h4000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [30:0] max_accel_reg, brake_decel_reg, max_vel_reg, safety_reg;
    logic [10:0] ticks_reg;
    logic [5:0]  path_edges_reg;

    // vehicle state
    logic [30:0] speed_reg;
    logic signed [31:0] accel_now_reg;
    logic [4:0]  cur_edge_reg;
    logic [30:0] offset_reg;
    logic [31:0] wait_cnt_reg, zero_cnt_reg;
    logic        ready_flag_reg;

    // latched request fields
    logic [30:0] lv_reg, lb_reg;
    logic signed [31:0] gap_reg;

    // edge-length memory, registered read
    logic [30:0] edge_mem [MAX_EDGES];
    logic [30:0] rd_data_reg;

    // arithmetic working registers
    logic [63:0]  prod_reg;
    logic [6:0]   cnt_reg;
    logic [61:0]  lvsq_reg, aa_reg;
    logic [21:0]  nn_reg;
    logic [41:0]  vn_reg;
    logic [58:0]  k_reg;
    logic [75:0]  a4vn_reg;
    logic         hneg_reg;
    logic [62:0]  hmag_reg;
    logic [127:0] kh_reg, p_reg, q_reg;
    logic [63:0]  div_q_reg;
    logic [32:0]  div_r_reg, div_d_reg;
    logic [127:0] sq_d_reg;
    logic [66:0]  sq_rem_reg;
    logic [63:0]  sq_root_reg;
    logic signed [65:0] diff_reg;
    logic [31:0]  walk_l_reg;
    logic [4:0]   walk_e_reg;

    // output register
    logic        m_valid_reg, m_kind_reg, m_runway_reg, m_last_reg;
    logic [4:0]  m_passed_reg, m_edge_now_reg;
    logic [30:0] m_vel_reg, m_off_reg;
    logic signed [31:0] m_accel_reg;
    logic [31:0] m_wait_reg, m_stop_reg;

    logic [10:0] n_eff;
    logic [5:0]  pe_eff;
    logic        out_free;
    logic        m_load;
    logic [31:0] mul_x, mul_y;

    assign n_eff    = (ticks_reg == 11'd0) ? 11'd1 : ticks_reg;
    assign pe_eff   = (path_edges_reg == 6'd0) ? 6'd1 :
                      (path_edges_reg > 6'(MAX_EDGES)) ? 6'(MAX_EDGES) : path_edges_reg;
    assign out_free = !m_valid_reg || m_ready;
    // output register takes a new result this cycle
    assign m_load   = out_free && ((state_reg == S_SUM) ||
                      ((state_reg == S_WALK) && (walk_l_reg > {1'b0, rd_data_reg})));

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    // shared 32x32 multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            S_MUL: begin
                case (cnt_reg)
                    7'd0: begin mul_x = {1'b0, lv_reg};        mul_y = {1'b0, lv_reg}; end
                    7'd1: begin mul_x = {1'b0, brake_decel_reg}; mul_y = {1'b0, brake_decel_reg}; end
                    7'd2: begin mul_x = {21'b0, n_eff};        mul_y = {21'b0, n_eff}; end
                    7'd3: begin mul_x = {1'b0, speed_reg};     mul_y = {21'b0, n_eff}; end
                    7'd4: begin mul_x = {1'b0, brake_decel_reg}; mul_y = {10'b0, nn_reg}; end
                    7'd5: begin mul_x = {1'b0, brake_decel_reg}; mul_y = vn_reg[31:0]; end
                    7'd6: begin mul_x = {1'b0, brake_decel_reg}; mul_y = {22'b0, vn_reg[41:32]}; end
                    default: begin mul_x = '0; mul_y = '0; end
                endcase
            end
            S_KH: begin
                case (cnt_reg)
                    7'd0: begin mul_x = k_reg[31:0];          mul_y = hmag_reg[31:0]; end
                    7'd1: begin mul_x = k_reg[31:0];          mul_y = {1'b0, hmag_reg[62:32]}; end
                    7'd2: begin mul_x = {5'b0, k_reg[58:32]}; mul_y = hmag_reg[31:0]; end
                    7'd3: begin mul_x = {5'b0, k_reg[58:32]}; mul_y = {1'b0, hmag_reg[62:32]}; end
                    default: begin mul_x = '0; mul_y = '0; end
                endcase
            end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
    end

    // combinational helpers for single-step datapaths
    logic [33:0]  div_rsh;
    logic [66:0]  sq_rsh, sq_trial;
    logic signed [65:0] h_full, half_acc;
    logic [43:0]  bco;
    logic signed [33:0] nv;
    logic [30:0]  nv_clamp;

    always_comb begin
        div_rsh  = {div_r_reg, div_q_reg[63]};
        sq_rsh   = {sq_rem_reg[64:0], sq_d_reg[127:126]};
        sq_trial = {1'b0, sq_root_reg, 2'b01};
        h_full   = $signed({{34{gap_reg[31]}}, gap_reg}) + $signed({2'b0, div_q_reg})
                   - $signed({35'b0, safety_reg});
        bco      = {13'b0, brake_decel_reg} + {1'b0, vn_reg, 1'b0};
        half_acc = (diff_reg >= 0) ? (diff_reg >>> 1) : ((diff_reg + 66'sd1) >>> 1);
        nv       = $signed({3'b0, speed_reg}) + $signed({{2{accel_now_reg[31]}}, accel_now_reg});
        if (nv > $signed({3'b0, max_vel_reg})) begin
            nv_clamp = max_vel_reg;
        end else if (nv < 0) begin
            nv_clamp = '0;
        end else begin
            nv_clamp = nv[30:0];
        end
    end

    // memory: write on load, registered read of the walking edge
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && (s_op == OP_LOAD) && ({1'b0, s_edge_slot} < 6'(MAX_EDGES))) begin
            edge_mem[s_edge_slot] <= s_edge_length;
        end
        rd_data_reg <= edge_mem[walk_e_reg];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_x * mul_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            max_accel_reg   <= 31'd65536;
            brake_decel_reg <= 31'd65536;
            max_vel_reg     <= 31'd655360;
            safety_reg      <= 31'd327680;
            ticks_reg       <= 11'd1;
            path_edges_reg  <= 6'd1;
            speed_reg       <= '0;
            accel_now_reg   <= '0;
            cur_edge_reg    <= '0;
            offset_reg      <= '0;
            wait_cnt_reg    <= '0;
            zero_cnt_reg    <= '0;
            ready_flag_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            cnt_reg         <= '0;
            walk_e_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_ACCEL:   max_accel_reg   <= cfg_data[30:0];
                    CFG_BRAKE_DECEL: brake_decel_reg <= cfg_data[30:0];
                    CFG_MAX_VEL:     max_vel_reg     <= cfg_data[30:0];
                    CFG_SAFETY_DIST: safety_reg      <= cfg_data[30:0];
                    CFG_TICKS:       ticks_reg       <= cfg_data[10:0];
                    CFG_PATH_EDGES:  path_edges_reg  <= cfg_data[5:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_op == OP_TICK) begin
                        lv_reg  <= s_leader_velocity;
                        lb_reg  <= (s_leader_brake == 31'd0) ? 31'd1 : s_leader_brake;
                        gap_reg <= s_gap;
                        cnt_reg <= '0;
                        if (s_stop_command) begin
                            if (wait_cnt_reg != CNT_MAX) wait_cnt_reg <= wait_cnt_reg + 32'd1;
                            accel_now_reg <= -$signed({1'b0, brake_decel_reg});
                            state_reg     <= S_UPD;
                        end else if (!s_has_leader) begin
                            accel_now_reg <= $signed({1'b0, max_accel_reg});
                            state_reg     <= S_UPD;
                        end else if (s_leader_braking) begin
                            accel_now_reg <= -$signed({1'b0, brake_decel_reg});
                            state_reg     <= S_UPD;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end

                // prod_reg holds the product issued on the previous step
                S_MUL: begin
                    cnt_reg <= (cnt_reg == 7'd7) ? 7'd64 : cnt_reg + 7'd1;
                    case (cnt_reg)
                        7'd1: lvsq_reg <= prod_reg[61:0];
                        7'd2: aa_reg   <= prod_reg[61:0];
                        7'd3: nn_reg   <= prod_reg[21:0];
                        7'd4: vn_reg   <= prod_reg[41:0];
                        7'd5: k_reg    <= {prod_reg[55:0], 3'b0};
                        7'd6: a4vn_reg <= {11'b0, prod_reg[62:0], 2'b0};
                        7'd7: begin
                            a4vn_reg  <= a4vn_reg + {prod_reg[41:0], 34'b0};
                            div_q_reg <= {2'b0, lvsq_reg};
                            div_r_reg <= '0;
                            div_d_reg <= {1'b0, lb_reg, 1'b0};
                            state_reg <= S_DIV;
                        end
                        default: ;
                    endcase
                end

                S_DIV, S_SDIV: begin
                    if (div_rsh >= {1'b0, div_d_reg}) begin
                        div_r_reg <= 33'(div_rsh - {1'b0, div_d_reg});
                        div_q_reg <= {div_q_reg[62:0], 1'b1};
                    end else begin
                        div_r_reg <= div_rsh[32:0];
                        div_q_reg <= {div_q_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        state_reg <= (state_reg == S_DIV) ? S_HCALC : S_RD;
                    end
                end

                S_HCALC: begin
                    hneg_reg  <= h_full[65];
                    hmag_reg  <= h_full[65] ? 63'(-h_full) : h_full[62:0];
                    cnt_reg   <= '0;
                    state_reg <= S_KH;
                end

                S_KH: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    case (cnt_reg)
                        7'd1: kh_reg <= {64'b0, prod_reg};
                        7'd2: kh_reg <= kh_reg + {32'b0, prod_reg, 32'b0};
                        7'd3: kh_reg <= kh_reg + {32'b0, prod_reg, 32'b0};
                        7'd4: begin
                            kh_reg    <= kh_reg + {prod_reg, 64'b0};
                            state_reg <= S_PQ;
                        end
                        default: ;
                    endcase
                end

                S_PQ: begin
                    p_reg     <= {66'b0, aa_reg} + (hneg_reg ? 128'd0 : kh_reg);
                    q_reg     <= {52'b0, a4vn_reg} + (hneg_reg ? kh_reg : 128'd0);
                    state_reg <= S_DIFF;
                end

                // negative discriminant clamps to zero
                S_DIFF: begin
                    sq_d_reg    <= (p_reg > q_reg) ? (p_reg - q_reg) : 128'd0;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= 7'd64;
                    state_reg   <= S_SQRT;
                end

                S_SQRT: begin
                    if (sq_rsh >= sq_trial) begin
                        sq_rem_reg  <= sq_rsh - sq_trial;
                        sq_root_reg <= {sq_root_reg[62:0], 1'b1};
                    end else begin
                        sq_rem_reg  <= sq_rsh;
                        sq_root_reg <= {sq_root_reg[62:0], 1'b0};
                    end
                    sq_d_reg <= {sq_d_reg[125:0], 2'b00};
                    cnt_reg  <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) state_reg <= S_ACC1;
                end

                S_ACC1: begin
                    diff_reg  <= $signed({2'b0, sq_root_reg}) - $signed({22'b0, bco});
                    state_reg <= S_ACC2;
                end

                // halve toward zero, cap at max_accel, floor at -2^31
                S_ACC2: begin
                    if (half_acc > $signed({35'b0, max_accel_reg})) begin
                        accel_now_reg <= $signed({1'b0, max_accel_reg});
                    end else if (half_acc < -66'sh8000_0000) begin
                        accel_now_reg <= 32'sh8000_0000;
                    end else begin
                        accel_now_reg <= half_acc[31:0];
                    end
                    state_reg <= S_UPD;
                end

                S_UPD: begin
                    speed_reg <= nv_clamp;
                    if (nv_clamp == 31'd0 && zero_cnt_reg != CNT_MAX) begin
                        zero_cnt_reg <= zero_cnt_reg + 32'd1;
                    end
                    div_q_reg  <= {nv_clamp, 33'b0};
                    div_r_reg  <= '0;
                    div_d_reg  <= {22'b0, n_eff};
                    cnt_reg    <= 7'd31;
                    walk_e_reg <= cur_edge_reg;
                    state_reg  <= S_SDIV;
                end

                // memory read of walk_e_reg lands in rd_data_reg for WALK
                S_RD: begin
                    if (cnt_reg == 7'd0) begin
                        walk_l_reg <= {1'b0, offset_reg} + {1'b0, div_q_reg[30:0]};
                    end
                    cnt_reg   <= 7'd1;
                    state_reg <= S_WALK;
                end

                S_WALK: begin
                    if (walk_l_reg > {1'b0, rd_data_reg}) begin
                        if (out_free) begin
                            m_valid_reg    <= 1'b1;
                            m_kind_reg     <= KIND_PASSED;
                            m_passed_reg   <= walk_e_reg;
                            m_vel_reg      <= '0;
                            m_accel_reg    <= '0;
                            m_edge_now_reg <= '0;
                            m_off_reg      <= '0;
                            m_runway_reg   <= 1'b0;
                            m_wait_reg     <= '0;
                            m_stop_reg     <= '0;
                            m_last_reg     <= 1'b0;
                            if ({1'b0, walk_e_reg} + 6'd1 < pe_eff) begin
                                walk_l_reg <= walk_l_reg - {1'b0, rd_data_reg};
                                walk_e_reg <= walk_e_reg + 5'd1;
                                state_reg  <= S_RD;
                            end else begin
                                ready_flag_reg <= 1'b1;
                                state_reg      <= S_SUM;
                            end
                        end
                    end else begin
                        state_reg <= S_SUM;
                    end
                end

                S_SUM: begin
                    if (out_free) begin
                        cur_edge_reg   <= walk_e_reg;
                        offset_reg     <= walk_l_reg[31] ? Q_MAX31 : walk_l_reg[30:0];
                        m_valid_reg    <= 1'b1;
                        m_kind_reg     <= KIND_SUMMARY;
                        m_passed_reg   <= '0;
                        m_vel_reg      <= speed_reg;
                        m_accel_reg    <= accel_now_reg;
                        m_edge_now_reg <= walk_e_reg;
                        m_off_reg      <= walk_l_reg[31] ? Q_MAX31 : walk_l_reg[30:0];
                        m_runway_reg   <= ready_flag_reg;
                        m_wait_reg     <= wait_cnt_reg;
                        m_stop_reg     <= zero_cnt_reg;
                        m_last_reg     <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_passed_edge   = m_passed_reg;
    assign m_new_velocity  = m_vel_reg;
    assign m_applied_accel = m_accel_reg;
    assign m_edge_now      = m_edge_now_reg;
    assign m_edge_offset   = m_off_reg;
    assign m_runway_ready  = m_runway_reg;
    assign m_waited_ticks  = m_wait_reg;
    assign m_stopped_ticks = m_stop_reg;
    assign m_last          = m_last_reg;

endmodule
